// ===== hdl/pcs_pkg.sv =====
// ============================================================================
// pcs_pkg
// Shared widths, codes, types and the precision split table for the
// prediction corrector symbolizer.
// ============================================================================
package pcs_pkg;

  localparam int MAX_PRECISION = 24;

  localparam int VAL_W    = 24;          // pred / real_req / previous value
  localparam int RNG_W    = 25;          // corrector range
  localparam int CORR_W   = RNG_W + 1;   // signed corrector and wrapped difference
  localparam int SYM_W    = 25;          // symbol and alphabet
  localparam int CTX_W    = 3;
  localparam int MODE_W   = 2;
  localparam int PREC_W   = 5;
  localparam int BITS_W   = 4;           // bitsSmall / bitsLow
  localparam int CUT_W    = 14;          // small cutoff, at most 2^13
  localparam int LOW_W    = 12;          // low bits, at most 12
  localparam int CFG_AW   = 1;
  localparam int CFG_DW   = 25;
  localparam int MAX_SYMS = 3;
  localparam int CNT_W    = 2;
  localparam int QDEPTH   = 4;
  localparam int QAW      = 2;
  localparam int DIV_STAGES = RNG_W;     // one dividend bit per stage

  localparam int IN_TDATA_W  = 48;       // pred, real_req
  localparam int OUT_TDATA_W = 56;       // symbol, alphabet, zero pad

  localparam logic [PREC_W-1:0] PREC_RESET  = 5'd16;

  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACROSS = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;

  localparam logic [CTX_W-1:0] CTX_HIGH_BASE = 3'd3;
  localparam logic [CTX_W-1:0] CTX_LOW_POS   = 3'd6;
  localparam logic [CTX_W-1:0] CTX_LOW_NEG   = 3'd7;

  typedef enum logic [CFG_AW-1:0] {
    CFG_PRECISION = 1'b0,
    CFG_RANGE     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [BITS_W-1:0] bs;
    logic [BITS_W-1:0] bl;
  } split_t;

  // Values derived from the configuration registers; static while items fly.
  typedef struct packed {
    logic [RNG_W-1:0]  r;
    logic [VAL_W-1:0]  half;
    logic [BITS_W-1:0] bl;
    logic              whole;
    logic [CUT_W-1:0]  cutoff;
    logic [CUT_W:0]    twoc1;
    logic [LOW_W-1:0]  low_mask;
    logic [VAL_W-1:0]  neg_lo;
    logic [SYM_W-1:0]  alpha_s;
    logic [SYM_W-1:0]  alpha_h;
    logic [SYM_W-1:0]  alpha_l;
    logic [SYM_W-1:0]  alpha_w;
  } pcs_cfg_t;

  typedef struct packed {
    logic [CTX_W-1:0] ctx;
    logic [SYM_W-1:0] alphabet;
    logic [SYM_W-1:0] symbol;
  } pcs_sym_t;

  typedef struct packed {
    logic [CNT_W-1:0]               cnt;
    pcs_sym_t [MAX_SYMS-1:0]        syms;
  } pcs_entry_t;

  // bitsSmall / bitsLow by saturated precision
  function automatic split_t split_lookup(input logic [PREC_W-1:0] p);
    split_t s;
    s.bs = p[BITS_W-1:0];
    s.bl = '0;
    unique case (p)
      5'd7:    s = '{bs: 4'd4,  bl: 4'd0};
      5'd8:    s = '{bs: 4'd5,  bl: 4'd0};
      5'd9:    s = '{bs: 4'd5,  bl: 4'd0};
      5'd10:   s = '{bs: 4'd5,  bl: 4'd0};
      5'd11:   s = '{bs: 4'd6,  bl: 4'd0};
      5'd12:   s = '{bs: 4'd7,  bl: 4'd0};
      5'd13:   s = '{bs: 4'd7,  bl: 4'd0};
      5'd14:   s = '{bs: 4'd8,  bl: 4'd0};
      5'd15:   s = '{bs: 4'd8,  bl: 4'd3};
      5'd16:   s = '{bs: 4'd9,  bl: 4'd4};
      5'd17:   s = '{bs: 4'd9,  bl: 4'd5};
      5'd18:   s = '{bs: 4'd10, bl: 4'd6};
      5'd19:   s = '{bs: 4'd10, bl: 4'd7};
      5'd20:   s = '{bs: 4'd11, bl: 4'd8};
      5'd21:   s = '{bs: 4'd12, bl: 4'd9};
      5'd22:   s = '{bs: 4'd13, bl: 4'd10};
      5'd23:   s = '{bs: 4'd14, bl: 4'd11};
      5'd24:   s = '{bs: 4'd14, bl: 4'd12};
      default: s = '{bs: p[BITS_W-1:0], bl: 4'd0};  // precision below 7
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/pcs_cfg.sv =====
// ============================================================================
// pcs_cfg
// Configuration registers and the registered values derived from them.
// ============================================================================
module pcs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pcs_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [pcs_pkg::CFG_DW-1:0]  cfg_wdata,
  output pcs_pkg::pcs_cfg_t           cfg
);
  import pcs_pkg::*;

  logic [PREC_W-1:0] precision_r;
  logic [RNG_W-1:0]  range_r;

  // level 1
  logic [PREC_W-1:0] p_sat;
  split_t            sp;
  logic [RNG_W-1:0]  r_nxt;
  logic [RNG_W-1:0]  r_r;
  logic [VAL_W-1:0]  half_r;
  logic [BITS_W-1:0] bs_r;
  logic [BITS_W-1:0] bl_r;

  // level 2
  logic [LOW_W-1:0]  low_mask_nxt, low_mask_r;
  logic [RNG_W-1:0]  cmax_nxt, cmax_r;
  logic [RNG_W-1:0]  rnd;
  logic [VAL_W-1:0]  neg_lo_nxt, neg_lo_r;
  logic              whole_nxt, whole_r;
  logic [SYM_W-1:0]  alpha_s_nxt, alpha_s_r;
  logic [CUT_W-1:0]  cutoff_nxt, cutoff_r;
  logic [CUT_W:0]    twoc1_nxt, twoc1_r;
  logic [SYM_W-1:0]  alpha_l_nxt, alpha_l_r;
  logic [SYM_W-1:0]  alpha_w_nxt, alpha_w_r;

  // level 3
  logic [SYM_W-1:0]  alpha_h_nxt, alpha_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precision_r <= PREC_RESET;
      range_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_PRECISION: precision_r <= cfg_wdata[PREC_W-1:0];
        CFG_RANGE:     range_r     <= cfg_wdata[RNG_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    if (precision_r == '0) begin
      p_sat = PREC_W'(1);
    end else if (precision_r > PREC_W'(MAX_PRECISION)) begin
      p_sat = PREC_W'(MAX_PRECISION);
    end else begin
      p_sat = precision_r;
    end
    sp    = split_lookup(p_sat);
    r_nxt = (range_r != '0) ? range_r : (RNG_W'(1) << p_sat);
  end

  always_comb begin
    low_mask_nxt = ~({LOW_W{1'b1}} << bl_r);
    cmax_nxt     = r_r - RNG_W'(1) - {1'b0, half_r};
    rnd          = {1'b0, half_r} + {{(RNG_W-LOW_W){1'b0}}, low_mask_nxt};
    neg_lo_nxt   = VAL_W'(rnd >> bl_r);          // ceil(half / 2^bl)
    whole_nxt    = (r_r <= (RNG_W'(1) << bs_r));
    alpha_s_nxt  = SYM_W'(1) << bs_r;
    cutoff_nxt   = CUT_W'(1) << (bs_r - BITS_W'(1));
    twoc1_nxt    = ((CUT_W+1)'(1) << bs_r) - (CUT_W+1)'(1);
    alpha_l_nxt  = SYM_W'(1) << bl_r;
    alpha_w_nxt  = r_r + SYM_W'(1);
    if (bl_r == '0) begin
      alpha_h_nxt = r_r - {{(SYM_W-CUT_W-1){1'b0}}, twoc1_r};
    end else begin
      alpha_h_nxt = SYM_W'(cmax_r >> bl_r) + {1'b0, neg_lo_r} + SYM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    half_r     <= r_nxt[RNG_W-1:1];
    bs_r       <= sp.bs;
    bl_r       <= sp.bl;
    low_mask_r <= low_mask_nxt;
    cmax_r     <= cmax_nxt;
    neg_lo_r   <= neg_lo_nxt;
    whole_r    <= whole_nxt;
    alpha_s_r  <= alpha_s_nxt;
    cutoff_r   <= cutoff_nxt;
    twoc1_r    <= twoc1_nxt;
    alpha_l_r  <= alpha_l_nxt;
    alpha_w_r  <= alpha_w_nxt;
    alpha_h_r  <= alpha_h_nxt;
  end

  assign cfg.r        = r_r;
  assign cfg.half     = half_r;
  assign cfg.bl       = bl_r;
  assign cfg.whole    = whole_r;
  assign cfg.cutoff   = cutoff_r;
  assign cfg.twoc1    = twoc1_r;
  assign cfg.low_mask = low_mask_r;
  assign cfg.neg_lo   = neg_lo_r;
  assign cfg.alpha_s  = alpha_s_r;
  assign cfg.alpha_h  = alpha_h_r;
  assign cfg.alpha_l  = alpha_l_r;
  assign cfg.alpha_w  = alpha_w_r;

endmodule

// ===== hdl/pcs_rem.sv =====
// ============================================================================
// pcs_rem
// Pipelined restoring remainder: |x| mod r, one quotient bit per stage.
// ============================================================================
module pcs_rem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [pcs_pkg::RNG_W-1:0]   in_u,
  input  logic                        in_neg,
  input  logic [pcs_pkg::MODE_W-1:0]  in_mode,
  input  logic [pcs_pkg::RNG_W-1:0]   r,
  output logic                        out_v,
  output logic [pcs_pkg::RNG_W-1:0]   out_rem,
  output logic                        out_neg,
  output logic [pcs_pkg::MODE_W-1:0]  out_mode
);
  import pcs_pkg::*;

  logic [DIV_STAGES-1:0] v_r;
  logic [RNG_W-1:0]      rem_r  [DIV_STAGES];
  logic [RNG_W-1:0]      u_r    [DIV_STAGES];
  logic                  neg_r  [DIV_STAGES];
  logic [MODE_W-1:0]     mode_r [DIV_STAGES];

  logic [DIV_STAGES-1:0] pr_v;
  logic [RNG_W-1:0]      pr_rem  [DIV_STAGES];
  logic [RNG_W-1:0]      pr_u    [DIV_STAGES];
  logic                  pr_neg  [DIV_STAGES];
  logic [MODE_W-1:0]     pr_mode [DIV_STAGES];
  logic [RNG_W:0]        trial   [DIV_STAGES];
  logic [RNG_W-1:0]      rem_nxt [DIV_STAGES];

  always_comb begin
    pr_v[0]    = in_v;
    pr_rem[0]  = '0;
    pr_u[0]    = in_u;
    pr_neg[0]  = in_neg;
    pr_mode[0] = in_mode;
    for (int k = 1; k < DIV_STAGES; k++) begin
      pr_v[k]    = v_r[k-1];
      pr_rem[k]  = rem_r[k-1];
      pr_u[k]    = u_r[k-1];
      pr_neg[k]  = neg_r[k-1];
      pr_mode[k] = mode_r[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      trial[k] = {pr_rem[k], pr_u[k][DIV_STAGES-1-k]};
      if (trial[k] >= {1'b0, r}) begin
        rem_nxt[k] = RNG_W'(trial[k] - {1'b0, r});
      end else begin
        rem_nxt[k] = trial[k][RNG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= pr_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        u_r[k]    <= pr_u[k];
        neg_r[k]  <= pr_neg[k];
        mode_r[k] <= pr_mode[k];
      end
    end
  end

  assign out_v    = v_r[DIV_STAGES-1];
  assign out_rem  = rem_r[DIV_STAGES-1];
  assign out_neg  = neg_r[DIV_STAGES-1];
  assign out_mode = mode_r[DIV_STAGES-1];

endmodule

// ===== hdl/pcs_front.sv =====
// ============================================================================
// pcs_front
// Accepts words, forms and wraps the corrector, classifies it into one to
// three symbols and hands the finished set to the queue.
// ============================================================================
module pcs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pcs_pkg::pcs_cfg_t           cfg,
  input  logic                        in_v,
  output logic                        in_ready,
  input  logic [pcs_pkg::MODE_W-1:0]  in_mode,
  input  logic [pcs_pkg::VAL_W-1:0]   in_pred,
  input  logic [pcs_pkg::VAL_W-1:0]   in_real,
  input  logic                        q_full,
  output logic                        push,
  output pcs_pkg::pcs_entry_t         entry
);
  import pcs_pkg::*;

  logic adv, acc;

  logic [VAL_W-1:0]         prev_r;
  logic [MODE_W-1:0]        mode_eff;
  logic [VAL_W-1:0]         ref_val;
  logic signed [RNG_W-1:0]  d;

  logic                     s0_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [MODE_W-1:0]        s0_mode_r, s1_mode_r, s2_mode_r, s3_mode_r, s4_mode_r;
  logic signed [RNG_W-1:0]  s0_d_r;
  logic signed [CORR_W-1:0] x, s1_x_r;
  logic [RNG_W-1:0]         u, s2_u_r;
  logic                     s2_neg_r;

  logic                     dv_v, dv_neg;
  logic [RNG_W-1:0]         dv_rem;
  logic [MODE_W-1:0]        dv_mode;

  logic [RNG_W-1:0]         m, s3_m_r, s4_m_r;
  logic signed [CORR_W-1:0] corr, s4_corr_r;

  logic signed [CORR_W-1:0] cs, sh;
  logic                     neg, small_hit;
  logic [SYM_W-1:0]         sym_small, sym_whole, sym_hi, sym_hi_nl, sym_low;
  logic [CTX_W-1:0]         ctx_small;
  pcs_entry_t               cls_nxt, cls_entry_r;
  logic                     cls_v_r;

  // whole pipe moves together; the classify register drains into the queue
  assign adv      = !cls_v_r || !q_full;
  assign acc      = in_v && adv;
  assign in_ready = adv;
  assign push     = cls_v_r && !q_full;
  assign entry    = cls_entry_r;

  always_comb begin
    mode_eff = (in_mode == MODE_RSVD) ? MODE_ACROSS : in_mode;
    ref_val  = (mode_eff == MODE_NONE) ? prev_r : in_pred;
    d        = $signed({1'b0, in_real}) - $signed({1'b0, ref_val});
    x        = {s0_d_r[RNG_W-1], s0_d_r} + $signed({2'b0, cfg.half});
    u        = s1_x_r[CORR_W-1] ? RNG_W'(-s1_x_r) : s1_x_r[RNG_W-1:0];
    m        = (dv_neg && dv_rem != '0) ? cfg.r - dv_rem : dv_rem;
    corr     = $signed({1'b0, s3_m_r}) - $signed({2'b0, cfg.half});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      cls_v_r <= 1'b0;
    end else begin
      if (acc) begin
        prev_r <= in_real;
      end
      if (adv) begin
        s0_v_r  <= acc;
        s1_v_r  <= s0_v_r;
        s2_v_r  <= s1_v_r;
        s3_v_r  <= dv_v;
        s4_v_r  <= s3_v_r;
        cls_v_r <= s4_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_mode_r   <= mode_eff;
      s0_d_r      <= d;
      s1_mode_r   <= s0_mode_r;
      s1_x_r      <= x;
      s2_mode_r   <= s1_mode_r;
      s2_neg_r    <= s1_x_r[CORR_W-1];
      s2_u_r      <= u;
      s3_mode_r   <= dv_mode;
      s3_m_r      <= m;
      s4_mode_r   <= s3_mode_r;
      s4_m_r      <= s3_m_r;
      s4_corr_r   <= corr;
      cls_entry_r <= cls_nxt;
    end
  end

  pcs_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (s2_v_r),
    .in_u     (s2_u_r),
    .in_neg   (s2_neg_r),
    .in_mode  (s2_mode_r),
    .r        (cfg.r),
    .out_v    (dv_v),
    .out_rem  (dv_rem),
    .out_neg  (dv_neg),
    .out_mode (dv_mode)
  );

  // classify
  always_comb begin
    cs        = $signed({{(CORR_W-CUT_W){1'b0}}, cfg.cutoff});
    neg       = s4_corr_r[CORR_W-1];
    small_hit = (s4_corr_r < cs) && (s4_corr_r > -cs);
    sym_small = SYM_W'(s4_corr_r + cs);
    sym_whole = s4_m_r + SYM_W'(1);
    sh        = s4_corr_r >>> cfg.bl;
    sym_hi    = SYM_W'(sh + $signed({2'b0, cfg.neg_lo}));
    sym_hi_nl = neg ? s4_m_r : s4_m_r - {{(SYM_W-CUT_W-1){1'b0}}, cfg.twoc1};
    sym_low   = SYM_W'(s4_corr_r[LOW_W-1:0] & cfg.low_mask);
    ctx_small = {1'b0, s4_mode_r};

    cls_nxt                  = '0;
    cls_nxt.syms[0].ctx      = ctx_small;
    cls_nxt.syms[0].alphabet = cfg.alpha_s;
    cls_nxt.cnt              = CNT_W'(1);
    if (cfg.whole) begin
      cls_nxt.syms[0].symbol   = sym_whole;
      cls_nxt.syms[0].alphabet = cfg.alpha_w;
    end else if (small_hit) begin
      cls_nxt.syms[0].symbol   = sym_small;
    end else begin
      // escape, then high part, then low part when low bits are in use
      cls_nxt.syms[0].symbol   = '0;
      cls_nxt.syms[1].ctx      = CTX_HIGH_BASE + ctx_small;
      cls_nxt.syms[1].alphabet = cfg.alpha_h;
      if (cfg.bl == '0) begin
        cls_nxt.syms[1].symbol   = sym_hi_nl;
        cls_nxt.cnt              = CNT_W'(2);
      end else begin
        cls_nxt.syms[1].symbol   = sym_hi;
        cls_nxt.syms[2].ctx      = neg ? CTX_LOW_NEG : CTX_LOW_POS;
        cls_nxt.syms[2].symbol   = sym_low;
        cls_nxt.syms[2].alphabet = cfg.alpha_l;
        cls_nxt.cnt              = CNT_W'(3);
      end
    end
  end

endmodule

// ===== hdl/pcs_fifo.sv =====
// ============================================================================
// pcs_fifo
// Short queue of classified symbol sets between front and back.
// ============================================================================
module pcs_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pcs_pkg::pcs_entry_t  din,
  input  logic                 pop,
  output pcs_pkg::pcs_entry_t  dout,
  output logic                 not_empty,
  output logic                 full
);
  import pcs_pkg::*;

  pcs_entry_t       mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QAW:0]     count_r;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == (QAW+1)'(QDEPTH));
  assign dout      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QAW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QAW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QAW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// ===== hdl/pcs_back.sv =====
// ============================================================================
// pcs_back
// Walks queue-head symbols into the output register, one per unstalled cycle.
// ============================================================================
module pcs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcs_pkg::pcs_entry_t  head,
  input  logic                 head_v,
  output logic                 pop,
  input  logic                 out_ready,
  output logic                 out_v,
  output pcs_pkg::pcs_sym_t    out_sym,
  output logic                 out_last
);
  import pcs_pkg::*;

  logic [CNT_W-1:0] idx_r;
  logic             out_v_r;
  pcs_sym_t         sym_r;
  logic             last_r;
  logic             load, take, is_last;

  assign load     = !out_v_r || out_ready;
  assign take     = load && head_v;
  assign is_last  = (idx_r == head.cnt - CNT_W'(1));
  assign pop      = take && is_last;
  assign out_v    = out_v_r;
  assign out_sym  = sym_r;
  assign out_last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        out_v_r <= head_v;
      end
      if (take) begin
        idx_r <= is_last ? '0 : idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sym_r  <= head.syms[idx_r];
      last_r <= is_last;
    end
  end

endmodule

// ===== hdl/prediction_corrector_symbolizer_top.sv =====
// ============================================================================
// prediction_corrector_symbolizer_top
// Residual binarizer: wraps real minus prediction (or previous real) into the
// corrector range and emits whole, small or escape+high(+low) symbols for an entropy coder.
// ============================================================================
//
//   port group | dir | word contents (low bits first)           | accepted when
//   -----------+-----+--------------------------------------------+---------------------
//   in_*       | in  | tdata: pred[23:0], real_req[47:24];       | in_tvalid & in_tready
//              |     | tuser: mode                                |
//   out_*      | out | tdata: symbol[24:0], alphabet[49:25], pad; | out_tvalid & out_tready
//              |     | tuser: context_res; tlast: last_of_item    |
//   cfg_*      | in  | addr 0 precision, 1 value_range            | cfg_we
//
// Each input word yields one to three output words; the back end emits one
// output word per cycle while out_tready holds, and the output word rate is
// what sets throughput.
// From acceptance of an input word to its first output word, the path runs
// through 3 prep stages, a 25-stage remainder pipe (one bit per stage),
// 3 finish stages, the queue and the output register.
// Reset is synchronous, active low; no clearing pass, ready the cycle after.
// The front stalls only when the 4-deep queue is full; the back stalls only
// on out_tready.
// Config writes take effect through registered levels and must come while idle.
// ============================================================================
module prediction_corrector_symbolizer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [pcs_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [pcs_pkg::CFG_DW-1:0]        cfg_wdata,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pcs_pkg::IN_TDATA_W-1:0]    in_tdata,   // pred, real_req
  input  logic [pcs_pkg::MODE_W-1:0]        in_tuser,   // mode
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pcs_pkg::OUT_TDATA_W-1:0]   out_tdata,  // symbol, alphabet, zero pad
  output logic [pcs_pkg::CTX_W-1:0]         out_tuser,  // context_res
  output logic                              out_tlast   // last_of_item
);
  import pcs_pkg::*;

  pcs_cfg_t   cfg;
  logic       push, pop, q_full, q_valid;
  pcs_entry_t q_din, q_head;
  pcs_sym_t   out_sym;

  // config registers plus pre-computed cutoffs, masks and alphabets
  pcs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // front: accept, wrap modulo range, classify into a symbol set
  pcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_v     (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (in_tuser),
    .in_pred  (in_tdata[VAL_W-1:0]),
    .in_real  (in_tdata[2*VAL_W-1:VAL_W]),
    .q_full   (q_full),
    .push     (push),
    .entry    (q_din)
  );

  // decouples the fixed-rate front from the symbol-serial back
  pcs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (q_din),
    .pop       (pop),
    .dout      (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  // back: one symbol word per cycle unless out_tready stalls it
  pcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .head_v    (q_valid),
    .pop       (pop),
    .out_ready (out_tready),
    .out_v     (out_tvalid),
    .out_sym   (out_sym),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W-2*SYM_W){1'b0}}, out_sym.alphabet, out_sym.symbol};
  assign out_tuser = out_sym.ctx;

endmodule

// ===== hdl/pcs_checker.sv =====
// ============================================================================
// pcs_checker
// Port-level checks on the result stream of the symbolizer.
// ============================================================================
module pcs_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [pcs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic [pcs_pkg::CTX_W-1:0]         out_tuser,
  input  logic                              out_tlast
);
  import pcs_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // a low symbol always closes its item
  a_low_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == CTX_LOW_POS || out_tuser == CTX_LOW_NEG) |-> out_tlast)
    else $error("low symbol not marked last");

  // a non-final small symbol is an escape
  a_escape_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast && out_tuser < CTX_HIGH_BASE |-> out_tdata[SYM_W-1:0] == '0)
    else $error("non-final small symbol is not an escape");

  // an escape is followed at once by its high symbol
  a_escape_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast && out_tuser < CTX_HIGH_BASE |=>
      out_tvalid && out_tuser >= CTX_HIGH_BASE && out_tuser < CTX_LOW_POS)
    else $error("escape not followed by a high symbol");

endmodule

bind prediction_corrector_symbolizer_top pcs_checker u_pcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
